// File: design/pcd_pkg.sv
// ----------------------------------------------------------------------------
// POCSAG codeword decoder package
// Shared types, constants and helper functions for the decoder block.
// ----------------------------------------------------------------------------
package pcd_pkg;

   // Text store sizing: one entry is kept free, so the store holds one less.
   localparam int TEXT_CAPACITY = 64;
   localparam int LEN_W         = $clog2(TEXT_CAPACITY);
   localparam int STORE_DEPTH   = TEXT_CAPACITY - 1;

   // Codeword checking constants.
   localparam logic [31:0] IDLE_WORD = 32'h7A89C197;
   localparam logic [10:0] BCH_GEN   = 11'h769;
   localparam int          SYN_W     = 11;

   // Request commands.
   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_TARGET_RIC   = 1'b0;
   localparam logic CSR_NUMERIC_MODE = 1'b1;

   // Characters that need special handling.
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_CR    = 7'h0D;
   localparam logic [6:0] CH_LF    = 7'h0A;

   typedef struct packed {
      logic              cmd;
      logic [31:0]       codeword;
      logic [3:0]        slot_index;
      logic signed [7:0] rx_level;
   } req_type;

   typedef struct packed {
      logic [20:0]       ric;
      logic [1:0]        call_function;
      logic signed [7:0] message_rssi;
      logic [15:0]       corrected_count;
      logic [15:0]       uncorrectable_count;
      logic              truncated;
      logic [6:0]        char_code;
      logic              last_char;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic fix_step;
      logic count_bad;
      logic classify;
      logic bit_step;
      logic trim_dec;
      logic rd_tail;
      logic emit_load;
      logic finish;
   } pcd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_flush;
      logic syn_zero;
      logic fix_found;
      logic fix_last;
      logic is_idle_word;
      logic is_address;
      logic msg_active;
      logic bit_last;
      logic text_empty;
      logic tail_blank;
      logic emit_last;
      logic out_free;
   } pcd_sts_type;

   // Syndrome column of a single bit: even parity in the top bit and the
   // BCH remainder of the word above the parity bit in the low ten bits.
   function automatic logic [SYN_W-1:0] syn_col(input int k);
      logic [30:0]      v;
      logic [SYN_W-1:0] r;
      v = '0;
      r = {1'b1, 10'b0};
      if (k > 0) begin
         v = 31'(1) << (k - 1);
         for (int b = 30; b >= 10; b--) begin
            if (v[b]) begin
               v = v ^ (31'(BCH_GEN) << (b - 10));
            end
         end
         r = {1'b1, v[9:0]};
      end
      return r;
   endfunction

   // Numeric pager symbol set.
   function automatic logic [6:0] num_char(input logic [3:0] sym);
      logic [6:0] c;
      unique case (sym)
         4'hA:    c = 7'h2A;
         4'hB:    c = 7'h55;
         4'hC:    c = 7'h20;
         4'hD:    c = 7'h2D;
         4'hE:    c = 7'h29;
         4'hF:    c = 7'h28;
         default: c = 7'h30 + 7'(sym);
      endcase
      return c;
   endfunction

endpackage

// File: design/pcd_datapath.sv
// ----------------------------------------------------------------------------
// POCSAG decoder datapath
// Holds the codeword, the error search, the message header, the character
// assembler, the text memory and the result register.
// ----------------------------------------------------------------------------
module pcd_datapath
   import pcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata,
   input  req_type     req_data,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  pcd_cmd_type cmd,
   output pcd_sts_type sts
);

   logic [20:0]        target_ff;
   logic               numeric_ff;
   logic [31:0]        word_ff;
   logic [3:0]         slot_ff;
   logic signed [7:0]  rssi_ff;
   logic [SYN_W-1:0]   syn_ff;
   logic [4:0]         iter_ff;
   logic               corrected_ff;
   logic               pending_ff;
   logic               active_ff;
   logic [20:0]        ric_ff;
   logic [1:0]         func_ff;
   logic signed [7:0]  mrssi_ff;
   logic [15:0]        fixed_ff;
   logic [15:0]        bad_ff;
   logic               trunc_ff;
   logic [19:0]        bits_ff;
   logic [4:0]         bitcnt_ff;
   logic [6:0]         accum_ff;
   logic [2:0]         ccnt_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   k_ff;
   logic [6:0]         store_ff [STORE_DEPTH];
   logic [6:0]         rd_data_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [SYN_W-1:0]   col [32];
   logic [SYN_W-1:0]   syn_in;
   logic [SYN_W-1:0]   fix_target;
   logic [31:0]        fix_match;
   logic [31:0]        fix_flip;
   logic [20:0]        word_ric;
   logic               ric_match;
   logic [6:0]         acc_new;
   logic [2:0]         cnt_new;
   logic               char_done;
   logic [6:0]         char_val;
   logic               char_keep;
   logic               store_full;
   logic               store_we;
   logic [LEN_W-1:0]   rd_addr;
   logic               out_free;

   // Syndrome columns and the syndrome of the incoming codeword.
   always_comb begin
      syn_in = '0;
      for (int k = 0; k < 32; k++) begin
         col[k] = syn_col(k);
         if (req_data.codeword[k]) begin
            syn_in = syn_in ^ syn_col(k);
         end
      end
   end

   // One trial bit per cycle; the second bit is found by matching columns.
   always_comb begin
      fix_target = syn_ff ^ col[iter_ff];
      for (int j = 0; j < 32; j++) begin
         fix_match[j] = (col[j] == fix_target);
      end
      fix_flip = (32'(1) << iter_ff) | fix_match;
   end

   assign word_ric  = {word_ff[30:13], slot_ff[3:1]};
   assign ric_match = (target_ff == '0) || (word_ric == target_ff);

   // Character assembler for the next data bit.
   always_comb begin
      acc_new    = accum_ff | (7'(bits_ff[19]) << ccnt_ff);
      cnt_new    = ccnt_ff + 3'd1;
      char_done  = cnt_new >= (numeric_ff ? 3'd4 : 3'd7);
      char_val   = numeric_ff ? num_char(acc_new[3:0]) : acc_new;
      char_keep  = (char_val >= CH_SPACE) || (char_val == CH_LF) || (char_val == CH_CR);
      store_full = (len_ff == LEN_W'(TEXT_CAPACITY - 1));
      store_we   = cmd.bit_step && char_done && char_keep && !store_full;
   end

   assign rd_addr  = cmd.rd_tail ? (len_ff - LEN_W'(1)) : k_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         numeric_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_RIC:   target_ff  <= csr_wdata;
            CSR_NUMERIC_MODE: numeric_ff <= csr_wdata[0];
            default:          target_ff  <= target_ff;
         endcase
      end
   end

   // Codeword capture and error search.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         corrected_ff <= 1'b0;
         iter_ff      <= '0;
      end else if (cmd.load) begin
         word_ff      <= req_data.codeword;
         slot_ff      <= req_data.slot_index;
         rssi_ff      <= req_data.rx_level;
         syn_ff       <= syn_in;
         iter_ff      <= '0;
         corrected_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else if (cmd.fix_step) begin
         iter_ff <= iter_ff + 5'd1;
         if (sts.fix_found) begin
            word_ff      <= word_ff ^ fix_flip;
            corrected_ff <= 1'b1;
         end
      end else if (cmd.classify) begin
         pending_ff <= (word_ff != IDLE_WORD) && !word_ff[31] && ric_match;
         bits_ff    <= word_ff[30:11];
      end else if (cmd.bit_step) begin
         bits_ff <= {bits_ff[18:0], 1'b0};
      end
   end

   // Message header, counters and character state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ric_ff    <= '0;
         func_ff   <= '0;
         mrssi_ff  <= '0;
         fixed_ff  <= '0;
         bad_ff    <= '0;
         trunc_ff  <= 1'b0;
         len_ff    <= '0;
         k_ff      <= '0;
         accum_ff  <= '0;
         ccnt_ff   <= '0;
         bitcnt_ff <= '0;
      end else begin
         if (cmd.count_bad && active_ff && bad_ff != 16'hFFFF) begin
            bad_ff <= bad_ff + 16'd1;
         end
         if (cmd.classify) begin
            bitcnt_ff <= '0;
            if (active_ff && corrected_ff && fixed_ff != 16'hFFFF) begin
               fixed_ff <= fixed_ff + 16'd1;
            end
         end
         if (cmd.bit_step) begin
            bitcnt_ff <= bitcnt_ff + 5'd1;
            if (char_done) begin
               accum_ff <= '0;
               ccnt_ff  <= '0;
               if (char_keep && store_full) begin
                  trunc_ff <= 1'b1;
               end
               if (store_we) begin
                  len_ff <= len_ff + LEN_W'(1);
               end
            end else begin
               accum_ff <= acc_new;
               ccnt_ff  <= cnt_new;
            end
         end
         if (cmd.trim_dec) begin
            len_ff <= len_ff - LEN_W'(1);
         end
         if (cmd.emit_load) begin
            k_ff <= k_ff + LEN_W'(1);
         end
         if (cmd.finish) begin
            active_ff <= 1'b0;
            len_ff    <= '0;
            k_ff      <= '0;
            accum_ff  <= '0;
            ccnt_ff   <= '0;
            if (pending_ff) begin
               active_ff <= 1'b1;
               ric_ff    <= word_ric;
               func_ff   <= word_ff[12:11];
               mrssi_ff  <= rssi_ff;
               fixed_ff  <= {15'd0, corrected_ff};
               bad_ff    <= '0;
               trunc_ff  <= 1'b0;
            end
         end
      end
   end

   // Text memory with a registered read port.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[len_ff] <= char_val;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_ff.ric                 <= ric_ff;
         rsp_ff.call_function       <= func_ff;
         rsp_ff.message_rssi        <= mrssi_ff;
         rsp_ff.corrected_count     <= fixed_ff;
         rsp_ff.uncorrectable_count <= bad_ff;
         rsp_ff.truncated           <= trunc_ff;
         rsp_ff.char_code           <= rd_data_ff;
         rsp_ff.last_char           <= sts.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status toward the controller.
   always_comb begin
      sts.in_flush     = (req_data.cmd == CMD_FLUSH);
      sts.syn_zero     = (syn_ff == '0);
      sts.fix_found    = (fix_target == '0) || (fix_match != '0);
      sts.fix_last     = (iter_ff == 5'd31);
      sts.is_idle_word = (word_ff == IDLE_WORD);
      sts.is_address   = !word_ff[31];
      sts.msg_active   = active_ff;
      sts.bit_last     = (bitcnt_ff == 5'd19);
      sts.text_empty   = (len_ff == '0);
      sts.tail_blank   = (rd_data_ff == CH_SPACE) || (rd_data_ff == CH_CR) ||
                         (rd_data_ff == CH_LF);
      sts.emit_last    = (k_ff == len_ff - LEN_W'(1));
      sts.out_free     = out_free;
   end

endmodule

// File: design/pcd_controller.sv
// ----------------------------------------------------------------------------
// POCSAG decoder controller
// Sequences capture, error search, classification, bit assembly, trimming
// and character output.
// ----------------------------------------------------------------------------
module pcd_controller
   import pcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output pcd_cmd_type cmd,
   input  pcd_sts_type sts
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_FIX       = 10'b0000000010,
      ST_CLASS     = 10'b0000000100,
      ST_BITS      = 10'b0000001000,
      ST_END       = 10'b0000010000,
      ST_TRIM_RD   = 10'b0000100000,
      ST_TRIM_CHK  = 10'b0001000000,
      ST_EMIT_RD   = 10'b0010000000,
      ST_EMIT_LOAD = 10'b0100000000,
      ST_FINISH    = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.in_flush ? ST_END : ST_FIX;
            end
         end
         ST_FIX: begin
            if (sts.syn_zero) begin
               state_in = ST_CLASS;
            end else if (sts.fix_found) begin
               cmd.fix_step = 1'b1;
               state_in     = ST_CLASS;
            end else if (sts.fix_last) begin
               cmd.count_bad = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.fix_step = 1'b1;
            end
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            if (sts.is_idle_word || sts.is_address) begin
               state_in = ST_END;
            end else if (sts.msg_active) begin
               state_in = ST_BITS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BITS: begin
            cmd.bit_step = 1'b1;
            if (sts.bit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_END: begin
            state_in = sts.msg_active ? ST_TRIM_RD : ST_FINISH;
         end
         ST_TRIM_RD: begin
            cmd.rd_tail = 1'b1;
            state_in    = sts.text_empty ? ST_FINISH : ST_TRIM_CHK;
         end
         ST_TRIM_CHK: begin
            if (sts.tail_blank) begin
               cmd.trim_dec = 1'b1;
               state_in     = ST_TRIM_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = sts.emit_last ? ST_FINISH : ST_EMIT_RD;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/pocsag_codeword_decoder_top.sv
// ----------------------------------------------------------------------------
// POCSAG codeword decoder top level
// Corrects pager codewords, assembles messages and emits them per character.
// ----------------------------------------------------------------------------
// Usage:
// A request carries one 32-bit codeword with its batch slot and signal
// strength, or a flush command. The block takes a request when req_valid is
// high and req_stall is low; it works on one request at a time.
// A codeword takes the accepting cycle and the error search, one trial bit per
// cycle; a correctable word then passes a classification step and, for a
// word of an open message, character assembly of its 20 data bits.
// A message that ends passes an end step, a tail read and check per trailing
// blank removed and for the final tail check, a read and a load per character
// sent and a closing step; the store holds up to 63 characters.
// Characters leave through an output register on rsp_valid/rsp_stall, one per
// handshake; a stalled receiver holds the block in its output phase.
// Configuration writes on csr_we, csr_index and csr_wdata are taken at any
// time and are meant to be made while the block is idle.
// Reset clears the open message, counters, configuration and the output.
// ----------------------------------------------------------------------------
module pocsag_codeword_decoder_top
   import pcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   pcd_cmd_type ctl_cmd;
   pcd_sts_type dp_sts;

   // Sequencer.
   pcd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (ctl_cmd),
      .sts       (dp_sts)
   );

   // Datapath with text memory and output register.
   pcd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (ctl_cmd),
      .sts       (dp_sts)
   );

endmodule
